>>> sv/xll_pkg.sv
`default_nettype none
package xll_pkg;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_READ      = 3'd2,
    REQ_REMOVE    = 3'd3,
    REQ_SEARCH    = 3'd4,
    REQ_CLEAR     = 3'd5
  } req_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture request, set walk start
    OP_RD_CUR,    // issue read of current node
    OP_STEP,      // evaluate current node, advance walk
    OP_INS,       // write new node, read old end link
    OP_INS_LINK,  // write updated end link
    OP_RM_HS,     // read head-side neighbour, update end pointers
    OP_RM_TS,     // fix head-side neighbour, read tail-side one
    OP_RM_FIN,    // fix tail-side neighbour, free removed slot
    OP_CLEAR,
    OP_RESP_OK,
    OP_RESP_MISS,
    OP_RESP_FULL,
    OP_RESP_HIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic       walk_end;   // current index null or step bound reached
    logic       hit;        // current node is the wanted one
    logic       full;       // no free slot
    logic       has_end;    // chosen end is non-null
    logic       hs_nz;
    logic       ts_nz;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/xor_linked_list_engine_top.sv
`default_nettype none
// XOR linked list engine: a list of data words kept in a node store with
// one XOR link per node; slot zero is the null index.
// Input channel (in_valid_i/in_ready_o) carries one request: insert front or
// back, read or remove at a signed position, search for a key, or clear.
// Output channel (out_valid_o/out_ready_i) returns one result per request:
// status, read word, found position and element count afterwards.
// One request is handled at a time. A walk for read, search or removal visits
// one node per pass through the read, wait and step states, reading the store
// and then waiting for its registered data; a walk that runs off the list
// ends with a miss. The next request is taken the cycle after the result
// transfer.
// A finished result sits in the output register until transferred; no new
// request is taken while it waits.
// Reset empties the list and marks every slot but zero free; the stores are
// not cleared, as no walk ever reaches an unwritten slot.
module xor_linked_list_engine_top
  import xll_pkg::*;
#(
  parameter int NODE_SLOTS = 64,
  parameter int VALUE_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [63:0] value_i,
  input  wire logic signed [6:0] position_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [63:0]      read_value_o,
  output logic [5:0]       found_position_o,
  output logic [5:0]       element_count_o
);
  cmd_t cmd;
  sts_t sts;

  xll_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i,
    .out_valid_o, .out_ready_i, .cmd_o(cmd), .sts_i(sts));

  xll_dp #(.NodeSlots(NODE_SLOTS), .ValueBits(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .req_type_i, .value_i, .position_i,
    .status_o, .read_value_o, .found_position_o, .element_count_o);
endmodule
`default_nettype wire

>>> sv/xll_ram.sv
`default_nettype none
module xll_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // single write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/xll_dp.sv
`default_nettype none
module xll_dp
  import xll_pkg::*;
#(
  parameter int NodeSlots = 64,
  parameter int ValueBits = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [63:0] value_i,
  input  wire logic signed [6:0] position_i,
  output logic [1:0]       status_o,
  output logic [63:0]      read_value_o,
  output logic [5:0]       found_position_o,
  output logic [5:0]       element_count_o
);
  localparam int IW = $clog2(NodeSlots);
  localparam int CW = $clog2(NodeSlots + 1);

  logic [IW-1:0] head_q, tail_q, cur_q, prv_q, nxt_q, new_q;
  logic [CW-1:0] cnt_q, steps_q;
  logic [NodeSlots-1:0] free_q;
  logic [2:0]  req_q;
  logic [ValueBits-1:0] key_q;
  logic [6:0]  left_q;
  logic        from_tail_q;
  logic [1:0]  status_q;
  logic [63:0] rdv_q;
  logic [5:0]  fpos_q;

  logic          lwe, vwe;
  logic [IW-1:0] lwa, lwd, vwa, raddr, lrd;
  logic [ValueBits-1:0] vrd;

  xll_ram #(.Width(IW), .Depth(NodeSlots)) u_link (
    .clk_i, .we_i(lwe), .waddr_i(lwa), .wdata_i(lwd), .raddr_i(raddr), .rdata_o(lrd));
  xll_ram #(.Width(ValueBits), .Depth(NodeSlots)) u_val (
    .clk_i, .we_i(vwe), .waddr_i(vwa), .wdata_i(key_q), .raddr_i(raddr), .rdata_o(vrd));

  // lowest free slot above zero
  logic [IW-1:0] slot;
  logic          slot_ok;
  always_comb begin
    slot = '0;
    slot_ok = 1'b0;
    for (int i = NodeSlots - 1; i >= 1; i--) begin
      if (free_q[i]) begin
        slot = IW'(i);
        slot_ok = 1'b1;
      end
    end
  end

  logic [IW-1:0] nx, endi, hs, ts;
  logic          is_search;
  assign nx        = lrd ^ prv_q;
  assign is_search = (req_q == REQ_SEARCH);
  assign endi      = (req_q == REQ_INS_BACK) ? tail_q : head_q;
  assign hs        = from_tail_q ? nxt_q : prv_q;
  assign ts        = from_tail_q ? prv_q : nxt_q;

  assign sts_o.walk_end = (cur_q == '0) || (steps_q == CW'(NodeSlots));
  assign sts_o.hit      = is_search ? (vrd == key_q) : (left_q == '0);
  assign sts_o.full     = !slot_ok;
  assign sts_o.has_end  = (endi != '0);
  assign sts_o.hs_nz    = (hs != '0);
  assign sts_o.ts_nz    = (ts != '0);

  // link and value store writes and read address
  always_comb begin
    lwe = 1'b0; vwe = 1'b0;
    lwa = cur_q; lwd = '0; vwa = new_q;
    raddr = cur_q;
    unique case (cmd_i.op)
      OP_INS: begin
        vwe = 1'b1; lwe = 1'b1; lwa = new_q; lwd = endi;
        raddr = endi;
      end
      OP_INS_LINK: begin
        lwe = sts_o.has_end; lwa = endi; lwd = lrd ^ new_q;
      end
      OP_RM_HS: raddr = hs;
      OP_RM_TS: begin
        lwe = 1'b1; lwa = hs; lwd = lrd ^ cur_q ^ ts; raddr = ts;
      end
      OP_RM_FIN: begin
        lwe = 1'b1; lwa = ts; lwd = lrd ^ cur_q ^ hs;
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; tail_q <= '0; cnt_q <= '0;
      free_q <= {{(NodeSlots-1){1'b1}}, 1'b0};
    end else begin
      unique case (cmd_i.op)
        OP_INS: begin
          free_q[new_q] <= 1'b0;
          cnt_q <= cnt_q + 1'b1;
        end
        // end pointers move in the same step that patches the old end link
        OP_INS_LINK: begin
          if (!sts_o.has_end) begin
            head_q <= new_q; tail_q <= new_q;
          end else if (req_q == REQ_INS_BACK) begin
            tail_q <= new_q;
          end else begin
            head_q <= new_q;
          end
        end
        OP_RM_HS: begin
          if (!sts_o.hs_nz) head_q <= ts;
          if (!sts_o.ts_nz) tail_q <= hs;
        end
        OP_RM_FIN: begin
          free_q[cur_q] <= 1'b1;
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        end
        OP_CLEAR: begin
          head_q <= '0; tail_q <= '0; cnt_q <= '0;
          free_q <= {{(NodeSlots-1){1'b1}}, 1'b0};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        req_q <= req_type_i;
        key_q <= value_i[ValueBits-1:0];
        from_tail_q <= position_i[6];
        left_q <= position_i[6] ? ~position_i : position_i;
        cur_q <= (req_type_i != REQ_SEARCH && position_i[6]) ? tail_q : head_q;
        prv_q <= '0; steps_q <= '0;
        new_q <= slot;
      end
      OP_STEP: begin
        if (!sts_o.hit) begin
          prv_q <= cur_q; cur_q <= nx;
          steps_q <= steps_q + 1'b1;
          left_q <= left_q - 1'b1;
        end else begin
          nxt_q <= nx;
        end
      end
      OP_RESP_OK, OP_RESP_MISS, OP_RESP_FULL: begin
        status_q <= (cmd_i.op == OP_RESP_OK) ? ST_OK :
                    (cmd_i.op == OP_RESP_FULL) ? ST_FULL : ST_MISS;
        rdv_q <= '0; fpos_q <= '0;
      end
      OP_RESP_HIT: begin
        status_q <= ST_OK;
        rdv_q <= (req_q == REQ_READ) ? 64'(vrd) : '0;
        fpos_q <= is_search ? 6'(steps_q) : '0;
      end
      default: ;
    endcase
  end

  assign status_o         = status_q;
  assign read_value_o     = rdv_q;
  assign found_position_o = fpos_q;
  assign element_count_o  = 6'(cnt_q);
endmodule
`default_nettype wire

>>> sv/xll_ctrl.sv
`default_nettype none
module xll_ctrl
  import xll_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] req_type_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output cmd_t            cmd_o,
  input  wire sts_t       sts_i
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_RD = 4'd2, S_WAIT = 4'd3,
                         S_STEP = 4'd4, S_INS2 = 4'd5, S_RM1 = 4'd6, S_RM2 = 4'd7,
                         S_RM3 = 4'd8, S_RESP = 4'd9, S_INSW = 4'd10;

  logic [3:0] state_q, state_d;
  logic [2:0] req_q;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        cmd_o.op = OP_LOAD; state_d = S_DISP;
      end
      S_DISP: begin
        state_d = S_RESP;
        case (req_q)
          REQ_INS_FRONT, REQ_INS_BACK: begin
            if (sts_i.full) cmd_o.op = OP_RESP_FULL;
            else begin cmd_o.op = OP_INS; state_d = S_INSW; end
          end
          REQ_READ, REQ_REMOVE, REQ_SEARCH: state_d = S_RD;
          REQ_CLEAR: cmd_o.op = OP_CLEAR;
          default: cmd_o.op = OP_RESP_MISS;
        endcase
        if (req_q == REQ_CLEAR) state_d = S_INS2;
      end
      S_INSW: begin cmd_o.op = OP_INS_LINK; state_d = S_INS2; end
      S_INS2: begin cmd_o.op = OP_RESP_OK; state_d = S_RESP; end
      S_RD: begin
        if (sts_i.walk_end) begin cmd_o.op = OP_RESP_MISS; state_d = S_RESP; end
        else state_d = S_WAIT;
      end
      S_WAIT: state_d = S_STEP;
      S_STEP: begin
        cmd_o.op = OP_STEP;
        if (!sts_i.hit) state_d = S_RD;
        else if (req_q == REQ_REMOVE) state_d = S_RM1;
        else begin cmd_o.op = OP_RESP_HIT; state_d = S_RESP; end
      end
      S_RM1: begin cmd_o.op = OP_RM_HS; state_d = S_RM2; end
      S_RM2: begin cmd_o.op = OP_RM_TS; state_d = S_RM3; end
      S_RM3: begin cmd_o.op = OP_RM_FIN; state_d = S_INS2; end
      S_RESP: begin out_valid_d = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_valid_q <= 1'b0; req_q <= REQ_INS_FRONT;
    end else begin
      state_q <= state_d; out_valid_q <= out_valid_d;
      if (cmd_o.op == OP_LOAD) req_q <= req_type_i;
    end
  end
endmodule
`default_nettype wire

>>> tb/xor_linked_list_engine_top_test.sv
`timescale 1ns / 100ps
module xor_linked_list_engine_top_test;
  import xll_pkg::*;

  localparam int SLOTS = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam logic [2:0] REQ_UNUSED6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED7 = 3'd7;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] rd;
    logic [5:0]  fpos;
    logic [5:0]  cnt;
  } resp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        req_type = REQ_INS_FRONT;
  logic [63:0]       value = '0;
  logic signed [6:0] position = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic [63:0]       read_value;
  logic [5:0]        found_position;
  logic [5:0]        element_count;

  // shadow list state
  int          link_mem [SLOTS];
  logic [63:0] word_mem [SLOTS];
  bit          slot_free [SLOTS];
  int          head_idx, tail_idx, n_elems;

  resp_t expected_q[$];
  logic [63:0] recent_words[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b1;
  bit long_hold = 1'b0;

  always #5 clk_i = ~clk_i;

  xor_linked_list_engine_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .req_type_i       (req_type),
    .value_i          (value),
    .position_i       (position),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .read_value_o     (read_value),
    .found_position_o (found_position),
    .element_count_o  (element_count)
  );

  function automatic int clamp_idx(int i);
    return (i >= 0 && i < SLOTS) ? i : 0;
  endfunction

  function automatic void list_reset();
    for (int i = 0; i < SLOTS; i++) slot_free[i] = (i != 0);
    head_idx = 0;
    tail_idx = 0;
    n_elems = 0;
  endfunction

  // walk to a signed position; neighbours given in walk order
  function automatic int find_node(int pos, output bit from_tail, output int pv_o,
                                   output int nx_o);
    int cur, pv, nx, left;
    pv = 0;
    pv_o = 0;
    nx_o = 0;
    from_tail = (pos < 0);
    cur = clamp_idx(from_tail ? tail_idx : head_idx);
    left = from_tail ? -(pos + 1) : pos;
    for (int s = 0; cur != 0 && s < SLOTS; s++) begin
      nx = clamp_idx(link_mem[cur] ^ pv);
      if (left == 0) begin
        pv_o = pv;
        nx_o = nx;
        return cur;
      end
      left--;
      pv = cur;
      cur = nx;
    end
    return 0;
  endfunction

  function automatic resp_t list_apply(logic [2:0] req, logic [63:0] w,
                                       logic signed [6:0] p);
    resp_t r;
    int t, cur, pv, nx, hs, ts, c, pr, n;
    bit ft;
    r.status = ST_OK;
    r.rd = '0;
    r.fpos = '0;
    case (req)
      REQ_INS_FRONT, REQ_INS_BACK: begin
        t = 0;
        for (int i = 1; i < SLOTS; i++)
          if (slot_free[i] && t == 0) t = i;
        if (t == 0) r.status = ST_FULL;
        else begin
          slot_free[t] = 0;
          word_mem[t] = w;
          if (n_elems == 0 || (req == REQ_INS_BACK ? tail_idx : head_idx) == 0) begin
            head_idx = t;
            tail_idx = t;
            link_mem[t] = 0;
          end else if (req == REQ_INS_BACK) begin
            link_mem[tail_idx] ^= t;
            link_mem[t] = tail_idx;
            tail_idx = t;
          end else begin
            link_mem[head_idx] ^= t;
            link_mem[t] = head_idx;
            head_idx = t;
          end
          n_elems++;
        end
      end
      REQ_READ: begin
        cur = find_node(p, ft, pv, nx);
        if (cur == 0) r.status = ST_MISS;
        else r.rd = word_mem[cur];
      end
      REQ_REMOVE: begin
        cur = find_node(p, ft, pv, nx);
        if (cur == 0) r.status = ST_MISS;
        else begin
          hs = ft ? nx : pv;
          ts = ft ? pv : nx;
          if (hs != 0) link_mem[hs] ^= cur ^ ts;
          else head_idx = ts;
          if (ts != 0) link_mem[ts] ^= cur ^ hs;
          else tail_idx = hs;
          slot_free[cur] = 1;
          if (n_elems > 0) n_elems--;
        end
      end
      REQ_SEARCH: begin
        c = clamp_idx(head_idx);
        pr = 0;
        r.status = ST_MISS;
        for (int k = 0; c != 0 && k < SLOTS; k++) begin
          n = clamp_idx(link_mem[c] ^ pr);
          if (word_mem[c] == w) begin
            r.status = ST_OK;
            r.fpos = k[5:0];
            break;
          end
          pr = c;
          c = n;
        end
      end
      REQ_CLEAR: list_reset();
      default: r.status = ST_MISS;
    endcase
    r.cnt = n_elems[5:0];
    return r;
  endfunction

  // offer one request and hold it until the transfer
  task automatic send_req(logic [2:0] req, logic [63:0] w, logic signed [6:0] p);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= req;
    value <= w;
    position <= p;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    expected_q.push_back(list_apply(req, w, p));
    if (req == REQ_INS_FRONT || req == REQ_INS_BACK) begin
      recent_words.push_back(w);
      if (recent_words.size() > 16) void'(recent_words.pop_front());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // result checker
  always @(posedge clk_i) begin
    resp_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          errors++;
        end
        if (read_value !== e.rd) begin
          $error("read_value: expected %h, got %h", e.rd, read_value);
          errors++;
        end
        if (found_position !== e.fpos) begin
          $error("found_position: expected %0d, got %0d", e.fpos, found_position);
          errors++;
        end
        if (element_count !== e.cnt) begin
          $error("element_count: expected %0d, got %0d", e.cnt, element_count);
          errors++;
        end
      end
    end
  end

  // receiver ready with random stalls and one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_empty_list();
    send_req(REQ_READ, '0, 7'sd0);
    send_req(REQ_READ, '0, -7'sd1);
    send_req(REQ_REMOVE, '0, 7'sd0);
    send_req(REQ_SEARCH, '0, 7'sd0);
    send_req(REQ_CLEAR, '0, 7'sd0);
    send_req(REQ_UNUSED6, '1, 7'sd63);
    send_req(REQ_UNUSED7, '1, -7'sd64);
  endtask

  task automatic test_basic_ops();
    send_req(REQ_INS_FRONT, 64'h0, 7'sd0);
    send_req(REQ_INS_BACK, '1, 7'sd0);
    send_req(REQ_INS_FRONT, 64'h8000_0000_0000_0001, 7'sd0);
    send_req(REQ_INS_BACK, 64'h1234_5678_9abc_def0, 7'sd0);
    send_req(REQ_READ, '0, 7'sd0);
    send_req(REQ_READ, '0, -7'sd1);
    send_req(REQ_READ, '0, 7'sd2);
    send_req(REQ_READ, '0, 7'sd4);
    send_req(REQ_READ, '0, -7'sd5);
    send_req(REQ_SEARCH, '1, 7'sd0);
    send_req(REQ_SEARCH, 64'h5, 7'sd0);
    send_req(REQ_REMOVE, '0, 7'sd1);
    send_req(REQ_REMOVE, '0, -7'sd1);
    send_req(REQ_REMOVE, '0, 7'sd0);
    send_req(REQ_UNUSED6, '0, 7'sd0);
    send_req(REQ_REMOVE, '0, -7'sd1);
    send_req(REQ_REMOVE, '0, 7'sd0);
  endtask

  // store full, position extremes and clear of a full list
  task automatic test_full_store();
    for (int i = 0; i < SLOTS; i++)
      send_req(i[0] ? REQ_INS_BACK : REQ_INS_FRONT, rand_word(), 7'sd0);
    send_req(REQ_INS_BACK, rand_word(), 7'sd0);
    send_req(REQ_READ, '0, 7'sd62);
    send_req(REQ_READ, '0, 7'sd63);
    send_req(REQ_READ, '0, -7'sd63);
    send_req(REQ_READ, '0, -7'sd64);
    send_req(REQ_SEARCH, recent_words[$], 7'sd0);
    send_req(REQ_REMOVE, '0, 7'sd31);
    send_req(REQ_INS_FRONT, 64'h0, 7'sd0);
    send_req(REQ_CLEAR, '0, 7'sd0);
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 8; i++) send_req(REQ_INS_BACK, rand_word(), 7'sd0);
    wait_drained();
    send_req(REQ_SEARCH, recent_words[$], 7'sd0);
  endtask

  task automatic test_random(int n_items);
    logic [2:0] req;
    logic [63:0] w;
    logic signed [6:0] p;
    int sel;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items - 100) idle_en = 1'b0;
      sel = $urandom_range(0, 99);
      w = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 7)) : rand_word();
      if (n_elems < 4 && sel >= 45) sel = $urandom_range(0, 44);
      if (sel < 45) req = sel[0] ? REQ_INS_BACK : REQ_INS_FRONT;
      else if (sel < 65) req = REQ_READ;
      else if (sel < 82) req = REQ_REMOVE;
      else if (sel < 95) req = REQ_SEARCH;
      else if (sel < 97) req = REQ_CLEAR;
      else req = $urandom_range(0, 1) ? REQ_UNUSED6 : REQ_UNUSED7;
      // mostly positions inside the list, some anywhere
      if (n_elems > 0 && $urandom_range(0, 4) != 0) begin
        p = $urandom_range(0, 1) ? 7'($urandom_range(0, n_elems - 1))
                                 : -7'($urandom_range(1, n_elems));
      end else begin
        p = 7'($urandom);
      end
      if (req == REQ_SEARCH && recent_words.size() > 0 && $urandom_range(0, 2) != 0)
        w = recent_words[$urandom_range(0, recent_words.size() - 1)];
      send_req(req, w, p);
    end
  endtask

  initial begin
    list_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_basic_ops();
    test_full_store();
    test_backpressure();
    test_random(300);
    wait_drained();
    repeat (250) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> xor_linked_list_engine_top.f
sv/xll_pkg.sv
sv/xll_ram.sv
sv/xll_dp.sv
sv/xll_ctrl.sv
sv/xor_linked_list_engine_top.sv
tb/xor_linked_list_engine_top_test.sv
